// ===== rtl/core/narp_pkg.sv =====
// narp_pkg: shared types, codes and constants of the note arpeggiator
// used by every module under rtl/core; depends on nothing else
`default_nettype none

package narp_pkg;

  localparam int MaxNotesDef = 16;
  localparam int NoteW       = 7;
  localparam int VelW        = 7;
  localparam int LfsrW       = 16;
  localparam int PhaseW      = 32;
  localparam int CfgW        = 32;

  localparam logic [LfsrW-1:0]  LfsrSeed  = 16'hACE1;
  localparam logic [LfsrW-1:0]  LfsrTaps  = 16'hB400;
  localparam logic [VelW-1:0]   VelOn     = 7'd102;  // 0.8 of full scale, rounded
  localparam logic [VelW-1:0]   VelOff    = 7'd0;
  localparam logic [PhaseW-1:0] PhaseInc  = 32'd256; // one sample in 24.8
  localparam logic [PhaseW-1:0] StepReset = 32'd2822400;

  typedef enum logic [1:0] {
    REQ_NOTE_ON,
    REQ_NOTE_OFF,
    REQ_ALL_OFF,
    REQ_TICK
  } req_e;

  typedef enum logic [1:0] {
    PAT_UP,
    PAT_DOWN,
    PAT_UPDOWN,
    PAT_RANDOM
  } pattern_e;

  typedef enum logic [1:0] {
    CFG_ENABLE,
    CFG_PATTERN,
    CFG_STEP
  } cfg_idx_e;

  typedef enum logic {
    EV_NOTE_OFF,
    EV_NOTE_ON
  } event_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_UPD,
    S_PHASE,
    S_DIV,
    S_PICK,
    S_OFF,
    S_ON
  } state_e;

  // command broadcast to every list cell
  typedef struct packed {
    logic             cmp;
    logic             ins;
    logic             del;
    logic [NoteW-1:0] key;
  } cell_op_t;

endpackage

`default_nettype wire

// ===== rtl/core/narp_cell.sv =====
// narp_cell: one slot of the sorted held-note list
// compares its note with the broadcast key and shifts with its neighbors; uses narp_pkg
`default_nettype none

module narp_cell (
  input  logic                    clk_i,
  input  narp_pkg::cell_op_t      op_i,
  input  logic                    occ_i,
  input  logic                    left_lt_i,
  input  logic [narp_pkg::NoteW-1:0] left_note_i,
  input  logic [narp_pkg::NoteW-1:0] right_note_i,
  output logic [narp_pkg::NoteW-1:0] note_o,
  output logic                    lt_o,
  output logic                    eq_o
);
  import narp_pkg::*;

  logic [NoteW-1:0] note_q, note_d;
  logic             lt_q, lt_d;
  logic             eq_q, eq_d;

  always_comb begin
    note_d = note_q;
    lt_d   = lt_q;
    eq_d   = eq_q;
    if (op_i.cmp) begin
      lt_d = occ_i && (note_q < op_i.key);
      eq_d = occ_i && (note_q == op_i.key);
    end
    // insert: cells above the slot take the left note, the slot takes the key
    if (op_i.ins && !lt_q) begin
      note_d = left_lt_i ? op_i.key : left_note_i;
    end
    // remove: the matching cell and all above take the right note
    if (op_i.del && !lt_q) begin
      note_d = right_note_i;
    end
  end

  always_ff @(posedge clk_i) begin
    note_q <= note_d;
    lt_q   <= lt_d;
    eq_q   <= eq_d;
  end

  assign note_o = note_q;
  assign lt_o   = lt_q;
  assign eq_o   = eq_q;

endmodule

`default_nettype wire

// ===== rtl/core/narp_mod.sv =====
// narp_mod: bit-serial remainder of the random word by the held-note count
// one dividend bit per cycle; uses narp_pkg
`default_nettype none

module narp_mod #(
  parameter int CntW = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [narp_pkg::LfsrW-1:0] dividend_i,
  input  logic [CntW-1:0]            divisor_i,
  output logic                       done_o,
  output logic [CntW-1:0]            rem_o
);
  import narp_pkg::*;

  localparam int BitW = $clog2(LfsrW);

  logic            busy_q;
  logic            done_q;
  logic [BitW-1:0] bit_q;
  logic [LfsrW-1:0] sh_q;
  logic [CntW-1:0] rem_q;
  logic [CntW-1:0] dvs_q;
  logic [CntW:0]   trial;
  logic [CntW:0]   trial_sub;

  always_comb begin
    trial     = {rem_q, sh_q[LfsrW-1]};
    trial_sub = trial - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        bit_q  <= '0;
      end else if (busy_q) begin
        bit_q <= bit_q + 1'b1;
        if (bit_q == BitW'(LfsrW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      sh_q  <= {sh_q[LfsrW-2:0], 1'b0};
      rem_q <= (trial >= {1'b0, dvs_q}) ? trial_sub[CntW-1:0] : trial[CntW-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== rtl/core/note_arpeggiator_unit.sv =====
// note_arpeggiator_unit: top level of the note arpeggiator
// uses narp_pkg, narp_cell (held-note list) and narp_mod (random index remainder)
`default_nettype none

// usage
// - input stream: s_axis_tuser carries the request kind (note on, note off,
//   all notes off, sample tick), s_axis_tdata the note number
// - output stream: one note event per transfer, m_axis_tuser its kind; a stepping
//   tick gives an optional note-off for the previous note, then a note-on with tlast set
// - configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 enable, 1 pattern, 2 step period in 24.8 samples); write only when idle
// - the held list is a row of cells; insert and remove are a broadcast
//   compare followed by a shift
// - flow: one item at a time; s_axis_tready is high only in the idle state
//   - note on / note off: compare state, then list update state, then idle
//   - all notes off, idle tick, tick without step: back to idle after compare or phase
//   - stepping tick: compare, phase, pick, note-off and note-on states; random adds a wait
//     on the bit-serial remainder unit (one bit of the 16-bit random word per cycle)
// - the note-off is loaded into the output register in the note-off state, the note-on
//   in the note-on state after it; the random pattern puts the remainder wait before both
// - output register: a result waits there while the receiver stalls; the
//   sequencer holds in its emit state until the register frees up
// - reset: list empty, phase zero, random seed loaded, enable set, up order
module note_arpeggiator_unit #(
  parameter int MaxNotes = narp_pkg::MaxNotesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [6:0] note_number, [7] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [6:0] note_number_out, [13:7] velocity_out,
                                      // [15:14] zero
  output logic        m_axis_tuser,   // [0] event_kind
  output logic        m_axis_tlast,   // last
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [narp_pkg::CfgW-1:0] cfg_data_i
);
  import narp_pkg::*;

  localparam int PW = $clog2(MaxNotes);
  localparam int CW = $clog2(MaxNotes + 1);

  // configuration registers
  logic              enable_q;
  pattern_e          pattern_q;
  logic [PhaseW-1:0] step_q;

  // sequencer and arpeggio state
  state_e            state_q, state_d;
  req_e              req_q;
  logic [NoteW-1:0]  key_q;
  logic [CW-1:0]     count_q, count_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic              down_q, down_d;
  logic              last_valid_q, last_valid_d;
  logic [NoteW-1:0]  last_note_q;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [PhaseW:0]   sum_q;
  logic [LfsrW-1:0]  lfsr_q, lfsr_d;
  logic [LfsrW-1:0]  lfsr_adv;
  logic [NoteW-1:0]  sel_note_q;

  // output register
  logic              out_valid_q;
  event_e            out_kind_q;
  logic [NoteW-1:0]  out_note_q;
  logic [VelW-1:0]   out_vel_q;
  logic              out_last_q;

  // cell row
  cell_op_t          cell_op;
  logic [NoteW-1:0]  cell_note [MaxNotes];
  logic [MaxNotes-1:0] cell_lt;
  logic [MaxNotes-1:0] cell_eq;

  // control
  logic              in_acc;
  logic              slot_free;
  logic              step_hit;
  logic              found;
  logic              full;
  logic              div_start;
  logic              div_done;
  logic [CW-1:0]     div_rem;
  logic              off_load;
  logic              on_load;
  logic [CW-1:0]     cnt_after_off;

  // step selection
  logic [CW-1:0]     pos_ext;
  logic [CW-1:0]     pos_inc;
  logic [CW-1:0]     idx_ext;
  logic [PW-1:0]     pick_idx;
  logic [PW-1:0]     pick_pos;
  logic              pick_down;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign slot_free = !out_valid_q || m_axis_tready;
  assign step_hit  = sum_q >= {1'b0, step_q};
  assign found     = |cell_eq;
  assign full      = count_q >= CW'(MaxNotes);
  assign lfsr_adv  = (lfsr_q >> 1) ^ (lfsr_q[0] ? LfsrTaps : '0);

  // ---------------------------------------------------------------------------
  // held-note list: a row of cells, neighbor to neighbor
  // ---------------------------------------------------------------------------
  for (genvar gi = 0; gi < MaxNotes; gi++) begin : g_cell
    logic             left_lt;
    logic [NoteW-1:0] left_note;
    logic [NoteW-1:0] right_note;
    logic             occ;

    if (gi == 0) begin : g_first
      // the bottom cell always sees "everything to the left is lower"
      assign left_lt   = 1'b1;
      assign left_note = key_q;
    end else begin : g_inner
      assign left_lt   = cell_lt[gi-1];
      assign left_note = cell_note[gi-1];
    end

    if (gi == MaxNotes - 1) begin : g_top
      assign right_note = cell_note[gi];
    end else begin : g_below
      assign right_note = cell_note[gi+1];
    end

    assign occ = CW'(gi) < count_q;

    narp_cell u_cell (
      .clk_i        (clk_i),
      .op_i         (cell_op),
      .occ_i        (occ),
      .left_lt_i    (left_lt),
      .left_note_i  (left_note),
      .right_note_i (right_note),
      .note_o       (cell_note[gi]),
      .lt_o         (cell_lt[gi]),
      .eq_o         (cell_eq[gi])
    );
  end

  // random index: lfsr word modulo the held count
  narp_mod #(
    .CntW (CW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (lfsr_adv),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_CMP;
      end
      S_CMP: begin
        case (req_q)
          REQ_NOTE_ON:  state_d = S_UPD;
          REQ_NOTE_OFF: state_d = S_UPD;
          REQ_ALL_OFF:  state_d = S_IDLE;
          REQ_TICK:     state_d = (enable_q && (count_q != '0)) ? S_PHASE : S_IDLE;
          default:      state_d = S_IDLE;
        endcase
      end
      S_UPD: begin
        state_d = S_IDLE;
      end
      S_PHASE: begin
        if (!step_hit) begin
          state_d = S_IDLE;
        end else if (pattern_q == PAT_RANDOM) begin
          state_d = S_DIV;
        end else begin
          state_d = S_PICK;
        end
      end
      S_DIV: begin
        if (div_done) state_d = S_PICK;
      end
      S_PICK: begin
        state_d = S_OFF;
      end
      S_OFF: begin
        if (!last_valid_q || slot_free) state_d = S_ON;
      end
      S_ON: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    cell_op.cmp = (state_q == S_CMP) && ((req_q == REQ_NOTE_ON) || (req_q == REQ_NOTE_OFF));
    cell_op.ins = (state_q == S_UPD) && (req_q == REQ_NOTE_ON) && !found && !full;
    cell_op.del = (state_q == S_UPD) && (req_q == REQ_NOTE_OFF) && found;
    cell_op.key = key_q;
    div_start   = (state_q == S_PHASE) && step_hit && (pattern_q == PAT_RANDOM);
    off_load    = (state_q == S_OFF) && last_valid_q && slot_free;
    on_load     = (state_q == S_ON) && slot_free;
  end

  assign s_axis_tready = (state_q == S_IDLE);

  // ---------------------------------------------------------------------------
  // next index and position for one step
  // ---------------------------------------------------------------------------
  always_comb begin
    pos_ext   = CW'(pos_q);
    pos_inc   = pos_ext + 1'b1;
    idx_ext   = pos_ext;
    pick_pos  = pos_q;
    pick_down = down_q;
    case (pattern_q)
      PAT_UP: begin
        pick_pos = (pos_inc == count_q) ? '0 : PW'(pos_inc);
      end
      PAT_DOWN: begin
        idx_ext  = (pos_ext < count_q) ? (count_q - 1'b1 - pos_ext) : '0;
        pick_pos = (pos_inc == count_q) ? '0 : PW'(pos_inc);
      end
      PAT_UPDOWN: begin
        if (!down_q) begin
          if (pos_inc >= count_q) begin
            // past the top: turn around one below it
            pick_pos  = (count_q >= CW'(2)) ? PW'(count_q - CW'(2)) : '0;
            pick_down = 1'b1;
          end else begin
            pick_pos = PW'(pos_inc);
          end
        end else begin
          if (pos_q == '0) begin
            pick_pos  = PW'(1);
            pick_down = 1'b0;
          end else begin
            pick_pos = pos_q - 1'b1;
          end
        end
        if (count_q == CW'(1)) pick_pos = '0;
      end
      PAT_RANDOM: begin
        idx_ext = div_rem;
      end
      default: begin
        idx_ext = pos_ext;
      end
    endcase
    if (idx_ext >= count_q) idx_ext = count_q - 1'b1;
    pick_idx = PW'(idx_ext);
  end

  // ---------------------------------------------------------------------------
  // arpeggio state update
  // ---------------------------------------------------------------------------
  assign cnt_after_off = found ? (count_q - 1'b1) : count_q;

  always_comb begin
    count_d      = count_q;
    pos_d        = pos_q;
    down_d       = down_q;
    last_valid_d = last_valid_q;
    phase_d      = phase_q;
    lfsr_d       = lfsr_q;
    case (state_q)
      S_CMP: begin
        if (req_q == REQ_ALL_OFF) begin
          count_d      = '0;
          pos_d        = '0;
          last_valid_d = 1'b0;
        end
      end
      S_UPD: begin
        if (cell_op.ins) begin
          count_d = count_q + 1'b1;
          pos_d   = '0;
          down_d  = 1'b0;
        end else if (req_q == REQ_NOTE_OFF) begin
          count_d = cnt_after_off;
          // keep the position inside the shortened list
          if ((cnt_after_off != '0) && (pos_ext >= cnt_after_off)) begin
            pos_d = PW'(cnt_after_off - 1'b1);
          end
        end
      end
      S_PHASE: begin
        if (step_hit) begin
          phase_d = sum_q[PhaseW-1:0] - step_q;
          if (pattern_q == PAT_RANDOM) lfsr_d = lfsr_adv;
        end else begin
          phase_d = sum_q[PhaseW-1:0];
        end
      end
      S_PICK: begin
        pos_d  = pick_pos;
        down_d = pick_down;
      end
      S_ON: begin
        if (slot_free) last_valid_d = 1'b1;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      pos_q        <= '0;
      down_q       <= 1'b0;
      last_valid_q <= 1'b0;
      last_note_q  <= '0;
      phase_q      <= '0;
      lfsr_q       <= LfsrSeed;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      pos_q        <= pos_d;
      down_q       <= down_d;
      last_valid_q <= last_valid_d;
      phase_q      <= phase_d;
      lfsr_q       <= lfsr_d;
      if (on_load) last_note_q <= sel_note_q;
      if (off_load || on_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b1;
      pattern_q <= PAT_UP;
      step_q    <= StepReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE:  enable_q  <= cfg_data_i[0];
        CFG_PATTERN: pattern_q <= pattern_e'(cfg_data_i[1:0]);
        CFG_STEP:    step_q    <= cfg_data_i[PhaseW-1:0];
        default:     enable_q  <= enable_q;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= req_e'(s_axis_tuser);
      key_q <= s_axis_tdata[NoteW-1:0];
    end
    if (state_q == S_CMP) sum_q <= {1'b0, phase_q} + {1'b0, PhaseInc};
    if (state_q == S_PICK) sel_note_q <= cell_note[pick_idx];
    if (off_load) begin
      out_kind_q <= EV_NOTE_OFF;
      out_note_q <= last_note_q;
      out_vel_q  <= VelOff;
      out_last_q <= 1'b0;
    end else if (on_load) begin
      out_kind_q <= EV_NOTE_ON;
      out_note_q <= sel_note_q;
      out_vel_q  <= VelOn;
      out_last_q <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_vel_q, out_note_q};
  assign m_axis_tuser  = logic'(out_kind_q);
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MaxNotes))
    else $error("held count above list size");

  a_pos_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (pos_ext < count_q))
    else $error("position outside held list");

  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("remainder finished outside its wait state");

  a_one_cell_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cell_op.cmp, cell_op.ins, cell_op.del}))
    else $error("more than one list command at once");

  a_on_after_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    on_load |=> (m_axis_tvalid && m_axis_tlast && last_valid_q))
    else $error("note-on transfer not presented after load");

endmodule

`default_nettype wire
